// ===== rtl/emboss_uv_shift_top_assert.svh =====
// Assertion macros for the emboss texture shift block.
// Included by emboss_uv_shift_top, the RTL file that carries concurrent assertions; needs nothing else.
`ifndef EMBOSS_UV_SHIFT_TOP_ASSERT_SVH
`define EMBOSS_UV_SHIFT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EUS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
`define EUS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("%m: assertion failed");
`else
`define EUS_ASSERT(lbl, clk, rst, prop)
`define EUS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/eus_pkg.sv =====
// Shared types, constants and rounding helper for the emboss texture shift block.
// Used by eus_norm, eus_shift and emboss_uv_shift_top; depends on nothing.
package eus_pkg;

   localparam int unsigned CoordW    = 32;
   localparam int unsigned DiffW     = 33;
   localparam int unsigned MagW      = 33;
   localparam int unsigned BlW       = 6;
   localparam int unsigned UnitBits  = 30;
   localparam int unsigned NormMagW  = 30;
   localparam int unsigned SqW       = 60;
   localparam int unsigned RadW      = 62;
   localparam int unsigned RootW     = 31;
   localparam int unsigned SqRemW    = 34;
   localparam int unsigned SqAccW    = 36;
   localparam int unsigned DvAccW    = 32;
   localparam int unsigned UnitW     = 32;
   localparam int unsigned ProdW     = 64;
   localparam int unsigned SqrtSteps = 31;
   localparam int unsigned DivSteps  = 31;
   localparam int unsigned NormFront = 6;
   localparam int unsigned NormLat   = NormFront + SqrtSteps + 1 + DivSteps + 1;
   localparam int unsigned ShiftLat  = 6;
   localparam int unsigned CsrIdxW   = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_LIGHT_X     = 3'd0,
      CSR_LIGHT_Y     = 3'd1,
      CSR_LIGHT_Z     = 3'd2,
      CSR_EMBOSS_GAIN = 3'd3
   } csr_index_type;

   typedef logic [2:0][DiffW-1:0] diff_vec_type;
   typedef logic [2:0][UnitW-1:0] unit_vec_type;

   typedef struct packed {
      logic signed [CoordW-1:0] corner_x;
      logic signed [CoordW-1:0] corner_y;
      logic signed [CoordW-1:0] corner_z;
      logic signed [CoordW-1:0] next_x;
      logic signed [CoordW-1:0] next_y;
      logic signed [CoordW-1:0] next_z;
      logic signed [CoordW-1:0] prev_x;
      logic signed [CoordW-1:0] prev_y;
      logic signed [CoordW-1:0] prev_z;
      logic signed [CoordW-1:0] base_u;
      logic signed [CoordW-1:0] base_v;
   } eus_req_type;

   typedef struct packed {
      logic signed [CoordW-1:0] shifted_u;
      logic signed [CoordW-1:0] shifted_v;
      logic                     degenerate;
   } eus_rsp_type;

   // Shifts right by the unit fraction width, rounding half away from zero.
   function automatic logic signed [ProdW-1:0] round_shr_unit(input logic signed [ProdW-1:0] x);
      logic             neg;
      logic [ProdW-1:0] m;
      neg = x[ProdW-1];
      m = neg ? (~x + 64'd1) : x;
      m = (m + (64'd1 << (UnitBits - 1))) >> UnitBits;
      return neg ? (~m + 64'd1) : m;
   endfunction

endpackage

// ===== rtl/eus_norm.sv =====
// Pipelined vector normalizer: magnitude alignment, squared sum, square root and division.
// Depends on eus_pkg; instantiated three times by emboss_uv_shift_top.
module eus_norm (
   input  logic                  clock,
   input  logic                  en,
   input  eus_pkg::diff_vec_type diff_in,
   output eus_pkg::unit_vec_type unit_out,
   output logic                  zero_out
);
   import eus_pkg::*;

   typedef struct packed {
      logic [2:0][NormMagW-1:0] mag;
      logic [2:0]               neg;
      logic                     zero;
   } side_type;

   logic [2:0]               neg1_ff, neg1_in;
   logic [2:0][MagW-1:0]     mag1_ff, mag1_in;
   logic [2:0]               neg2_ff;
   logic [2:0][MagW-1:0]     mag2_ff;
   logic [MagW-1:0]          max2_ff, max2_in;
   logic [2:0]               neg3_ff;
   logic [2:0][MagW-1:0]     mag3_ff;
   logic [BlW-1:0]           bl3_ff, bl3_in;
   logic                     zero3_ff;
   logic [2:0]               neg4_ff;
   logic [2:0][NormMagW-1:0] mag4_ff, mag4_in;
   logic                     zero4_ff;
   logic [2:0][SqW-1:0]      sq5_ff, sq5_in;
   side_type                 side5_ff;

   logic [RadW-1:0]          sq_rad_ff  [SqrtSteps+1];
   logic [RootW-1:0]         sq_root_ff [SqrtSteps+1];
   logic [SqRemW-1:0]        sq_rem_ff  [SqrtSteps+1];
   side_type                 sq_side_ff [SqrtSteps+1];

   logic [RootW-1:0]         dv_r_ff    [DivSteps+1];
   logic [2:0][RootW-1:0]    dv_rem_ff  [DivSteps+1];
   logic [2:0][RootW-1:0]    dv_nb_ff   [DivSteps+1];
   logic [2:0][RootW-1:0]    dv_q_ff    [DivSteps+1];
   logic [2:0]               dv_neg_ff  [DivSteps+1];
   logic                     dv_zero_ff [DivSteps+1];

   unit_vec_type             unit_ff;
   logic                     zero_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = diff_in[i][DiffW-1];
         mag1_in[i] = neg1_in[i] ? MagW'(~diff_in[i] + 1'b1) : diff_in[i];
      end
   end

   always_comb begin
      max2_in = mag1_ff[0];
      if (mag1_ff[1] > max2_in) begin
         max2_in = mag1_ff[1];
      end
      if (mag1_ff[2] > max2_in) begin
         max2_in = mag1_ff[2];
      end
   end

   always_comb begin
      bl3_in = '0;
      for (int b = 0; b < MagW; b++) begin
         if (max2_ff[b]) begin
            bl3_in = BlW'(b + 1);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (bl3_ff > BlW'(UnitBits)) begin
            mag4_in[i] = NormMagW'(mag3_ff[i] >> (bl3_ff - BlW'(UnitBits)));
         end else begin
            mag4_in[i] = NormMagW'(mag3_ff[i] << (BlW'(UnitBits) - bl3_ff));
         end
         sq5_in[i] = SqW'(mag4_ff[i]) * SqW'(mag4_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff  <= neg1_in;
         mag1_ff  <= mag1_in;
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         max2_ff  <= max2_in;
         neg3_ff  <= neg2_ff;
         mag3_ff  <= mag2_ff;
         bl3_ff   <= bl3_in;
         zero3_ff <= (max2_ff == '0);
         neg4_ff  <= neg3_ff;
         mag4_ff  <= mag4_in;
         zero4_ff <= zero3_ff;
         sq5_ff   <= sq5_in;
         side5_ff <= '{mag: mag4_ff, neg: neg4_ff, zero: zero4_ff};
         sq_rad_ff[0]  <= RadW'(sq5_ff[0]) + RadW'(sq5_ff[1]) + RadW'(sq5_ff[2]);
         sq_root_ff[0] <= '0;
         sq_rem_ff[0]  <= '0;
         sq_side_ff[0] <= side5_ff;
      end
   end

   for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
      logic [SqAccW-1:0] acc;
      logic [SqAccW-1:0] trial;
      logic              ge;

      always_comb begin
         acc   = {sq_rem_ff[k], sq_rad_ff[k][RadW-1 -: 2]};
         trial = SqAccW'({sq_root_ff[k], 2'b01});
         ge    = (acc >= trial);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rad_ff[k+1]  <= sq_rad_ff[k] << 2;
            sq_root_ff[k+1] <= {sq_root_ff[k][RootW-2:0], ge};
            sq_rem_ff[k+1]  <= ge ? SqRemW'(acc - trial) : acc[SqRemW-1:0];
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end
   end

   // The numerator is mag * 2^30 + floor(R / 2); its top bits start the remainder.
   always_ff @(posedge clock) begin
      if (en) begin
         dv_r_ff[0]    <= sq_root_ff[SqrtSteps];
         dv_neg_ff[0]  <= sq_side_ff[SqrtSteps].neg;
         dv_zero_ff[0] <= sq_side_ff[SqrtSteps].zero;
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= RootW'(sq_side_ff[SqrtSteps].mag[i][NormMagW-1:1]);
            dv_nb_ff[0][i]  <= {sq_side_ff[SqrtSteps].mag[i][0],
                                sq_root_ff[SqrtSteps][RootW-1:1]};
            dv_q_ff[0][i]   <= '0;
         end
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_div
      logic [2:0][DvAccW-1:0] acc;
      logic [2:0]             ge;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            acc[i] = {dv_rem_ff[k][i], dv_nb_ff[k][i][RootW-1]};
            ge[i]  = (acc[i] >= DvAccW'(dv_r_ff[k]));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_r_ff[k+1]    <= dv_r_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_zero_ff[k+1] <= dv_zero_ff[k];
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[k+1][i] <= ge[i] ? RootW'(acc[i] - DvAccW'(dv_r_ff[k]))
                                          : acc[i][RootW-1:0];
               dv_nb_ff[k+1][i]  <= dv_nb_ff[k][i] << 1;
               dv_q_ff[k+1][i]   <= {dv_q_ff[k][i][RootW-2:0], ge[i]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= dv_zero_ff[DivSteps];
         for (int i = 0; i < 3; i++) begin
            if (dv_zero_ff[DivSteps]) begin
               unit_ff[i] <= '0;
            end else if (dv_neg_ff[DivSteps][i]) begin
               unit_ff[i] <= UnitW'(~{1'b0, dv_q_ff[DivSteps][i]} + 1'b1);
            end else begin
               unit_ff[i] <= {1'b0, dv_q_ff[DivSteps][i]};
            end
         end
      end
   end

   assign unit_out = unit_ff;
   assign zero_out = zero_ff;

endmodule

// ===== rtl/eus_shift.sv =====
// Dot products, gain scaling and saturating texture shift; the last stage is the result register.
// Depends on eus_pkg; instantiated by emboss_uv_shift_top.
module eus_shift (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  eus_pkg::unit_vec_type       in_ue,
   input  eus_pkg::unit_vec_type       in_uf,
   input  eus_pkg::unit_vec_type       in_ul,
   input  logic                        in_degenerate,
   input  logic signed [31:0]          in_base_u,
   input  logic signed [31:0]          in_base_v,
   input  logic signed [31:0]          gain,
   output logic                        out_valid,
   output eus_pkg::eus_rsp_type        out_data
);
   import eus_pkg::*;

   localparam logic signed [ProdW-1:0] SatMax = 64'sd2147483647;
   localparam logic signed [ProdW-1:0] SatMin = -64'sd2147483648;

   logic [ShiftLat-1:0]        vld_ff;
   logic signed [CoordW-1:0]   bu_ff [ShiftLat-1];
   logic signed [CoordW-1:0]   bv_ff [ShiftLat-1];
   logic                       dg_ff [ShiftLat-1];

   logic signed [ProdW-1:0]    pe_ff [3];
   logic signed [ProdW-1:0]    pf_ff [3];
   logic signed [ProdW-1:0]    se_ff, sf_ff;
   logic signed [CoordW-1:0]   de_ff, df_ff;
   logic signed [ProdW-1:0]    ge_ff, gf_ff;
   logic signed [ProdW-1:0]    he_ff, hf_ff;
   logic signed [ProdW-1:0]    te_in, tf_in;
   eus_rsp_type                rsp_ff, rsp_in;

   always_comb begin
      te_in = {{32{bu_ff[ShiftLat-2][CoordW-1]}}, bu_ff[ShiftLat-2]} + he_ff;
      tf_in = {{32{bv_ff[ShiftLat-2][CoordW-1]}}, bv_ff[ShiftLat-2]} + hf_ff;
      rsp_in.degenerate = dg_ff[ShiftLat-2];
      if (te_in > SatMax) begin
         rsp_in.shifted_u = SatMax[CoordW-1:0];
      end else if (te_in < SatMin) begin
         rsp_in.shifted_u = SatMin[CoordW-1:0];
      end else begin
         rsp_in.shifted_u = te_in[CoordW-1:0];
      end
      if (tf_in > SatMax) begin
         rsp_in.shifted_v = SatMax[CoordW-1:0];
      end else if (tf_in < SatMin) begin
         rsp_in.shifted_v = SatMin[CoordW-1:0];
      end else begin
         rsp_in.shifted_v = tf_in[CoordW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[ShiftLat-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bu_ff[0] <= in_base_u;
         bv_ff[0] <= in_base_v;
         dg_ff[0] <= in_degenerate;
         for (int k = 1; k < ShiftLat - 1; k++) begin
            bu_ff[k] <= bu_ff[k-1];
            bv_ff[k] <= bv_ff[k-1];
            dg_ff[k] <= dg_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            pe_ff[i] <= ProdW'($signed(in_ue[i])) * ProdW'($signed(in_ul[i]));
            pf_ff[i] <= ProdW'($signed(in_uf[i])) * ProdW'($signed(in_ul[i]));
         end
         se_ff  <= pe_ff[0] + pe_ff[1] + pe_ff[2];
         sf_ff  <= pf_ff[0] + pf_ff[1] + pf_ff[2];
         de_ff  <= CoordW'(round_shr_unit(se_ff));
         df_ff  <= CoordW'(round_shr_unit(sf_ff));
         ge_ff  <= ProdW'(de_ff) * ProdW'(gain);
         gf_ff  <= ProdW'(df_ff) * ProdW'(gain);
         he_ff  <= round_shr_unit(ge_ff);
         hf_ff  <= round_shr_unit(gf_ff);
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vld_ff[ShiftLat-1];
   assign out_data  = rsp_ff;

endmodule

// ===== rtl/emboss_uv_shift_top.sv =====
// Top level of the emboss texture shift block: registers, difference stage, normalizers, shift.
// Depends on eus_pkg, eus_norm, eus_shift and emboss_uv_shift_top_assert.svh.
//
// Each transfer on the req channel is one triangle corner with its next and previous
// corners and its original texture coordinates; each rsp transfer returns the shifted
// coordinates and a flag set when the light, next or previous vector has zero length.
// The csr channel writes the light position and the emboss gain; csr_ready is always
// high and writes to unused indexes are dropped. Write it only while the block is idle.
// One corner is accepted every cycle while req_stall is low. A result passes through
// one difference stage, 70 normalizer stages (31 square-root steps and 31 divide steps
// with their setup) and six stages of dot product, gain and saturation.
// When rsp_stall holds a waiting result, the whole pipeline freezes and req_stall
// rises in the same cycle; nothing is dropped or repeated. Synchronous reset empties
// the pipeline, clears the light position and loads the default gain of 0.02.
`include "emboss_uv_shift_top_assert.svh"

module emboss_uv_shift_top #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  eus_pkg::eus_req_type             req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output eus_pkg::eus_rsp_type             rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [eus_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [eus_pkg::CoordW-1:0]       csr_wdata
);
   import eus_pkg::*;

   localparam logic signed [CoordW-1:0] GainReset =
      CoordW'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);

   logic                       en;
   logic signed [CoordW-1:0]   light_x_ff, light_y_ff, light_z_ff, gain_ff;
   diff_vec_type               dl_in, de_in, df_in;
   diff_vec_type               dl_ff, de_ff, df_ff;
   logic                       vld0_ff;
   logic signed [CoordW-1:0]   bu0_ff, bv0_ff;
   logic [NormLat-1:0]         line_vld_ff;
   logic signed [CoordW-1:0]   line_bu_ff [NormLat];
   logic signed [CoordW-1:0]   line_bv_ff [NormLat];
   unit_vec_type               ul, ue, uf;
   logic                       zl, ze, zf;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= '0;
         light_y_ff <= '0;
         light_z_ff <= '0;
         gain_ff    <= GainReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LIGHT_X:     light_x_ff <= csr_wdata;
            CSR_LIGHT_Y:     light_y_ff <= csr_wdata;
            CSR_LIGHT_Z:     light_z_ff <= csr_wdata;
            CSR_EMBOSS_GAIN: gain_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      dl_in[0] = {light_x_ff[CoordW-1], light_x_ff} - {req_data.corner_x[CoordW-1], req_data.corner_x};
      dl_in[1] = {light_y_ff[CoordW-1], light_y_ff} - {req_data.corner_y[CoordW-1], req_data.corner_y};
      dl_in[2] = {light_z_ff[CoordW-1], light_z_ff} - {req_data.corner_z[CoordW-1], req_data.corner_z};
      de_in[0] = {req_data.next_x[CoordW-1], req_data.next_x} - {req_data.corner_x[CoordW-1], req_data.corner_x};
      de_in[1] = {req_data.next_y[CoordW-1], req_data.next_y} - {req_data.corner_y[CoordW-1], req_data.corner_y};
      de_in[2] = {req_data.next_z[CoordW-1], req_data.next_z} - {req_data.corner_z[CoordW-1], req_data.corner_z};
      df_in[0] = {req_data.prev_x[CoordW-1], req_data.prev_x} - {req_data.corner_x[CoordW-1], req_data.corner_x};
      df_in[1] = {req_data.prev_y[CoordW-1], req_data.prev_y} - {req_data.corner_y[CoordW-1], req_data.corner_y};
      df_in[2] = {req_data.prev_z[CoordW-1], req_data.prev_z} - {req_data.corner_z[CoordW-1], req_data.corner_z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff     <= 1'b0;
         line_vld_ff <= '0;
      end else if (en) begin
         vld0_ff     <= req_valid;
         line_vld_ff <= {line_vld_ff[NormLat-2:0], vld0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff         <= dl_in;
         de_ff         <= de_in;
         df_ff         <= df_in;
         bu0_ff        <= req_data.base_u;
         bv0_ff        <= req_data.base_v;
         line_bu_ff[0] <= bu0_ff;
         line_bv_ff[0] <= bv0_ff;
         for (int k = 1; k < NormLat; k++) begin
            line_bu_ff[k] <= line_bu_ff[k-1];
            line_bv_ff[k] <= line_bv_ff[k-1];
         end
      end
   end

   eus_norm u_norm_light (
      .clock    (clock),
      .en       (en),
      .diff_in  (dl_ff),
      .unit_out (ul),
      .zero_out (zl)
   );

   eus_norm u_norm_next (
      .clock    (clock),
      .en       (en),
      .diff_in  (de_ff),
      .unit_out (ue),
      .zero_out (ze)
   );

   eus_norm u_norm_prev (
      .clock    (clock),
      .en       (en),
      .diff_in  (df_ff),
      .unit_out (uf),
      .zero_out (zf)
   );

   eus_shift u_shift (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (line_vld_ff[NormLat-1]),
      .in_ue         (ue),
      .in_uf         (uf),
      .in_ul         (ul),
      .in_degenerate (zl || ze || zf),
      .in_base_u     (line_bu_ff[NormLat-1]),
      .in_base_v     (line_bv_ff[NormLat-1]),
      .gain          (gain_ff),
      .out_valid     (rsp_valid),
      .out_data      (rsp_data)
   );

   `EUS_ASSERT_ALWAYS(a_csr_reset_values, clock, reset |=> gain_ff == GainReset && light_x_ff == '0)
   `EUS_ASSERT(a_light_x_write, clock, reset, csr_valid && csr_ready && csr_index == CSR_LIGHT_X |=> light_x_ff == $past(csr_wdata))
   `EUS_ASSERT(a_stall_holds_line, clock, reset, req_stall |=> $stable(line_vld_ff))

endmodule
